@@ rtl/core/lspe_pkg.sv @@
// Package for the line sensor position encoder: sizes, codes and the pattern table.
`timescale 1ns / 1ps

package lspe_pkg;

    // Sensor channel count and derived widths.
    localparam int NumCh     = 8;
    localparam int ChW       = $clog2(NumCh);
    localparam int SampleW   = 8;
    localparam int ThrW      = 10;
    localparam int CodeW     = 5;
    localparam int CountW    = 4;
    localparam int CfgIndexW = 4;

    // Last channel of a sweep.
    localparam logic [ChW-1:0] LastCh = ChW'(NumCh - 1);

    // Position codes with a special meaning.
    localparam logic [CodeW-1:0] CodeNone     = 5'd0;
    localparam logic [CodeW-1:0] CodeClear    = 5'd27;
    localparam logic [CodeW-1:0] CodeInit     = 5'd31;
    localparam logic [CodeW-1:0] CodeCrossLo  = 5'd20;
    localparam logic [CodeW-1:0] CodeCrossHi  = 5'd22;

    // More hits than this flag an intersection.
    localparam logic [CountW-1:0] CrossCount = 4'd5;

    // Reset value of each channel threshold.
    function automatic logic [ThrW-1:0] thr_reset(input logic [ChW-1:0] ch);
        logic [ThrW-1:0] val;
        case (ch)
            3'd0:    val = 10'd350;
            3'd1:    val = 10'd350;
            3'd2:    val = 10'd325;
            3'd3:    val = 10'd350;
            3'd4:    val = 10'd400;
            3'd5:    val = 10'd350;
            3'd6:    val = 10'd350;
            3'd7:    val = 10'd300;
            default: val = 10'd350;
        endcase
        return val;
    endfunction

    // Map a hit pattern to a position code; CodeNone marks an unlisted pattern.
    function automatic logic [CodeW-1:0] map_pattern(input logic [NumCh-1:0] p);
        logic [CodeW-1:0] code;
        case (p)
            8'h80:   code = 5'd1;
            8'hC0:   code = 5'd2;
            8'h40:   code = 5'd3;
            8'h60:   code = 5'd4;
            8'h20:   code = 5'd5;
            8'h30:   code = 5'd6;
            8'h10:   code = 5'd7;
            8'h18:   code = 5'd8;
            8'h08:   code = 5'd9;
            8'h0C:   code = 5'd10;
            8'h04:   code = 5'd11;
            8'h06:   code = 5'd12;
            8'h02:   code = 5'd13;
            8'h03:   code = 5'd14;
            8'h01:   code = 5'd15;
            8'hE0:   code = 5'd16;
            8'hF0:   code = 5'd17;
            8'hF8:   code = 5'd18;
            8'hFC:   code = 5'd19;
            8'hFE:   code = 5'd20;
            8'hFF:   code = 5'd21;
            8'h7F:   code = 5'd22;
            8'h3F:   code = 5'd23;
            8'h1F:   code = 5'd24;
            8'h0F:   code = 5'd25;
            8'h07:   code = 5'd26;
            8'h00:   code = CodeClear;
            default: code = CodeNone;
        endcase
        return code;
    endfunction

endpackage

@@ rtl/core/line_sensor_position_encoder.sv @@
// Top level of the line sensor position encoder.
`timescale 1ns / 1ps

// Line sensor position encoder.
// The input channel (in_valid, in_stall, sample) carries one converter sample
// per item; an internal counter assigns the items to channels 0..7 in turn.
// Each sample times four is compared against its channel threshold, and the
// hits build an 8-bit pattern and a hit count over the sweep.
// The item for channel 7 produces one result item on the output channel
// (out_valid, out_stall and the five result fields); other items produce none.
// The result is in the output register in the cycle after the channel 7 item is
// accepted. Throughput: one item per cycle while in_stall is low, set by the single
// compare and the pattern table between the state registers and the output register.
// When the receiver stalls, the result holds; items for channels 0..6 are still
// accepted, and only the channel 7 item waits until the output register frees.
// The user must write thresholds through cfg_wr_en, cfg_index and cfg_data while idle,
// which the block itself does not enforce; writes to an index above 7 are ignored.
// Reset clears the channel counter, pattern and count, sets the position and
// last position codes to 31 and loads the default thresholds.
module line_sensor_position_encoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [lspe_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [lspe_pkg::ThrW-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [lspe_pkg::SampleW-1:0]  sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [lspe_pkg::CodeW-1:0]    position,
    output logic [lspe_pkg::CodeW-1:0]    prev_position,
    output logic                          intersection,
    output logic [lspe_pkg::CountW-1:0]   hit_count,
    output logic [lspe_pkg::NumCh-1:0]    hit_pattern
);
    import lspe_pkg::*;

    logic [ThrW-1:0]   thr_reg [NumCh];
    logic [ChW-1:0]    chan_reg, chan_next;
    logic [NumCh-1:0]  pattern_reg, pattern_next;
    logic [CountW-1:0] count_reg, count_next;
    logic [CodeW-1:0]  pos_reg, pos_next;
    logic [CodeW-1:0]  last_reg, last_next;

    logic              out_valid_reg, out_valid_next;
    logic [CodeW-1:0]  out_pos_reg, out_last_reg;
    logic              out_inter_reg, out_inter_next;
    logic [CountW-1:0] out_count_reg;
    logic [NumCh-1:0]  out_pattern_reg;

    logic              accept;
    logic              sweep_end;
    logic              hit;
    logic [ThrW-1:0]   scaled;
    logic [NumCh-1:0]  pattern_acc;
    logic [CountW-1:0] count_acc;
    logic [CodeW-1:0]  mapped;

    // Only the item that closes a sweep needs the output register free.
    assign in_stall  = out_valid_reg && out_stall && (chan_reg == LastCh);
    assign accept    = in_valid && !in_stall;
    assign sweep_end = accept && (chan_reg == LastCh);

    // Threshold registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumCh; i++)
            begin
                thr_reg[i] <= thr_reset(ChW'(i));
            end
        end
        else if (cfg_wr_en && (cfg_index < CfgIndexW'(NumCh)))
        begin
            thr_reg[cfg_index[ChW-1:0]] <= cfg_data;
        end
    end

    // Compare the sample and fold the hit into the sweep.
    always_comb
    begin
        scaled      = {sample, 2'b00};
        hit         = scaled > thr_reg[chan_reg];
        pattern_acc = pattern_reg;
        count_acc   = count_reg;
        if (hit)
        begin
            pattern_acc[LastCh - chan_reg] = 1'b1;
            count_acc = count_reg + CountW'(1);
        end
        mapped = map_pattern(pattern_acc);

        chan_next    = chan_reg;
        pattern_next = pattern_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        last_next    = last_reg;
        if (accept)
        begin
            if (chan_reg == LastCh)
            begin
                chan_next    = '0;
                pattern_next = '0;
                count_next   = '0;
                if (pos_reg != CodeClear)
                begin
                    last_next = pos_reg;
                end
                if (mapped != CodeNone)
                begin
                    pos_next = mapped;
                end
            end
            else
            begin
                chan_next    = chan_reg + ChW'(1);
                pattern_next = pattern_acc;
                count_next   = count_acc;
            end
        end

        out_inter_next = (count_acc > CrossCount) ||
                         ((pos_next >= CodeCrossLo) && (pos_next <= CodeCrossHi));

        out_valid_next = out_valid_reg && out_stall;
        if (sweep_end)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Sweep state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg      <= '0;
            pattern_reg   <= '0;
            count_reg     <= '0;
            pos_reg       <= CodeInit;
            last_reg      <= CodeInit;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            chan_reg      <= chan_next;
            pattern_reg   <= pattern_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload register, loaded at the end of a sweep.
    always_ff @(posedge clk)
    begin
        if (sweep_end)
        begin
            out_pos_reg     <= pos_next;
            out_last_reg    <= last_next;
            out_inter_reg   <= out_inter_next;
            out_count_reg   <= count_acc;
            out_pattern_reg <= pattern_acc;
        end
    end

    assign out_valid     = out_valid_reg;
    assign position      = out_pos_reg;
    assign prev_position = out_last_reg;
    assign intersection  = out_inter_reg;
    assign hit_count     = out_count_reg;
    assign hit_pattern   = out_pattern_reg;

    // The item that closes a sweep always yields a result next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        sweep_end |=> out_valid)
        else $error("sweep end did not produce a result item");

    // The hit count matches the number of bits in the pattern.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hit_count == CountW'($countones(hit_pattern))))
        else $error("hit count disagrees with hit pattern");

    // The intersection flag follows the count and the position code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (intersection == ((hit_count > CrossCount) ||
                       ((position >= CodeCrossLo) && (position <= CodeCrossHi)))))
        else $error("intersection flag inconsistent");

    // The last position never holds the all-clear code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (prev_position != CodeClear))
        else $error("last position holds the all-clear code");

endmodule

@@ sim/line_sensor_position_encoder_tb.sv @@
// Self-checking testbench for the line sensor position encoder.
`timescale 1ns / 1ps

module line_sensor_position_encoder_tb;

    import lspe_pkg::*;

    // Register indexes of the threshold bank; indexes past the last one are unused.
    localparam logic [CfgIndexW-1:0] ThrIndexFirst = 4'd0;
    localparam logic [CfgIndexW-1:0] ThrIndexLast  = 4'd7;
    localparam int                   ThrMax        = 1023;

    // Listed sensor patterns, position code 1 first, the all-clear pattern last.
    localparam int                LineCodes    = 27;
    localparam logic [27*8-1:0]   LinePatterns = {
        8'h80, 8'hC0, 8'h40, 8'h60, 8'h20, 8'h30, 8'h10, 8'h18, 8'h08,
        8'h0C, 8'h04, 8'h06, 8'h02, 8'h03, 8'h01, 8'hE0, 8'hF0, 8'hF8,
        8'hFC, 8'hFE, 8'hFF, 8'h7F, 8'h3F, 8'h1F, 8'h0F, 8'h07, 8'h00
    };

    localparam int LongHold    = 60;
    localparam int IdleSettle  = 4;
    localparam int ReportLimit = 100;

    typedef enum int {THR_ALL_ZERO, THR_ALL_MAX, THR_MIXED} thr_plan_t;

    typedef struct {
        logic [SampleW-1:0] value;
        bit                 wait_drain;
    } sensor_item_t;

    typedef struct packed {
        logic [CodeW-1:0]  position;
        logic [CodeW-1:0]  prev_position;
        logic              intersection;
        logic [CountW-1:0] hit_count;
        logic [NumCh-1:0]  hit_pattern;
    } line_report_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_wr_en     = 1'b0;
    logic [CfgIndexW-1:0] cfg_index     = '0;
    logic [ThrW-1:0]      cfg_data      = '0;
    logic                 in_valid      = 1'b0;
    logic                 in_stall;
    logic [SampleW-1:0]   sample        = '0;
    logic                 out_valid;
    logic                 out_stall     = 1'b0;
    logic [CodeW-1:0]     position;
    logic [CodeW-1:0]     prev_position;
    logic                 intersection;
    logic [CountW-1:0]    hit_count;
    logic [NumCh-1:0]     hit_pattern;

    // Shadow state of the encoder.
    logic [ThrW-1:0]   thr_model [NumCh];
    logic [ChW-1:0]    chan_model;
    logic [NumCh-1:0]  pattern_model;
    logic [CountW-1:0] count_model;
    logic [CodeW-1:0]  pos_model;
    logic [CodeW-1:0]  last_model;

    sensor_item_t sample_queue[$];
    line_report_t expected_reports[$];

    int items_queued   = 0;
    int items_accepted = 0;
    int sweeps_issued  = 0;
    int sweeps_checked = 0;
    int error_count    = 0;
    int gap_left       = 0;
    int stall_left     = 0;
    int hold_left      = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    bit send_idling    = 1'b0;
    bit recv_idling    = 1'b0;

    line_sensor_position_encoder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .position      (position),
        .prev_position (prev_position),
        .intersection  (intersection),
        .hit_count     (hit_count),
        .hit_pattern   (hit_pattern)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < ReportLimit)
            $display("%0t lspe_tb: %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Position code of a pattern, or the none code when the pattern is not listed.
    function automatic logic [CodeW-1:0] position_for(input logic [NumCh-1:0] pat);
        logic [CodeW-1:0] code;
        code = CodeNone;
        for (int i = 0; i < LineCodes; i++)
        begin
            if (LinePatterns[(LineCodes - 1 - i) * 8 +: 8] == pat)
                code = CodeW'(i + 1);
        end
        return code;
    endfunction

    // Advances the shadow encoder by one sample; a finished sweep adds an expected report.
    task automatic advance_sensor_model(input logic [SampleW-1:0] value, output bit emitted);
        logic [ThrW-1:0]  scaled;
        logic [CodeW-1:0] code;
        line_report_t     rep;
        scaled = {value, 2'b00};
        if (scaled > thr_model[chan_model])
        begin
            pattern_model[LastCh - chan_model] = 1'b1;
            count_model = count_model + CountW'(1);
        end
        emitted = 1'b0;
        if (chan_model != LastCh)
        begin
            chan_model = chan_model + ChW'(1);
        end
        else
        begin
            if (pos_model != CodeClear)
                last_model = pos_model;
            code = position_for(pattern_model);
            if (code != CodeNone)
                pos_model = code;
            rep.position      = pos_model;
            rep.prev_position = last_model;
            rep.intersection  = (count_model > CrossCount) ||
                                (pos_model >= CodeCrossLo && pos_model <= CodeCrossHi);
            rep.hit_count     = count_model;
            rep.hit_pattern   = pattern_model;
            expected_reports.push_back(rep);
            pattern_model = '0;
            count_model   = '0;
            chan_model    = '0;
            emitted       = 1'b1;
        end
    endtask

    // Sample for a channel that lands on the chosen side of its threshold, often at the boundary.
    function automatic logic [SampleW-1:0] sample_for(input int ch, input bit hit);
        int unsigned bound;
        int unsigned val;
        bound = thr_model[ch] / 4;
        if (hit && bound >= 255)
            val = 255;
        else if (hit)
            val = ($urandom_range(0, 3) == 0) ? bound + 1 : $urandom_range(bound + 1, 255);
        else
            val = ($urandom_range(0, 3) == 0) ? bound : $urandom_range(0, bound);
        return SampleW'(val);
    endfunction

    task automatic push_sample(input logic [SampleW-1:0] value, input bit drain);
        sensor_item_t it;
        it.value      = value;
        it.wait_drain = drain;
        sample_queue.push_back(it);
        items_queued++;
    endtask

    // One sweep of full-scale and zero samples following a pattern.
    task automatic queue_extreme_sweep(input logic [NumCh-1:0] pat);
        for (int ch = 0; ch < NumCh; ch++)
            push_sample(pat[LastCh - ch] ? 8'hFF : 8'h00, 1'b0);
    endtask

    // Mostly sweeps aimed at listed patterns, some at arbitrary ones, some pure noise.
    task automatic queue_random_sweeps(input int count, input int drain_every);
        logic [NumCh-1:0] target;
        int unsigned      pick;
        bit               drain;
        for (int s = 0; s < count; s++)
        begin
            pick   = $urandom_range(0, 9);
            target = LinePatterns[$urandom_range(0, LineCodes - 1) * 8 +: 8];
            if (pick >= 7)
                target = NumCh'($urandom);
            drain = (drain_every != 0) && (s % drain_every == 0);
            for (int ch = 0; ch < NumCh; ch++)
            begin
                if (pick == 9)
                    push_sample(SampleW'($urandom), drain && ch == 0);
                else
                    push_sample(sample_for(ch, target[LastCh - ch]), drain && ch == 0);
            end
        end
    endtask

    task automatic write_threshold(input logic [CfgIndexW-1:0] index, input logic [ThrW-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (index <= ThrIndexLast)
            thr_model[index[ChW-1:0]] = value;
    endtask

    // Writes every threshold, sometimes an unused index as well, and returns at a falling edge.
    task automatic program_thresholds(input thr_plan_t plan);
        logic [ThrW-1:0] value;
        int unsigned     pick;
        for (int ch = 0; ch < NumCh; ch++)
        begin
            pick  = $urandom_range(0, 5);
            value = ThrW'($urandom_range(0, ThrMax));
            if (plan == THR_ALL_ZERO || (plan == THR_MIXED && pick == 0))
                value = '0;
            else if (plan == THR_ALL_MAX || (plan == THR_MIXED && pick == 1))
                value = ThrW'(ThrMax);
            else if (pick == 2)
                value = ThrW'($urandom_range(1015, ThrMax));
            write_threshold(ThrIndexFirst + CfgIndexW'(ch), value);
        end
        if (plan == THR_MIXED && $urandom_range(0, 1) == 0)
            write_threshold(CfgIndexW'($urandom_range(ThrIndexLast + 1, 2**CfgIndexW - 1)),
                            ThrW'($urandom));
        @(negedge clk);
    endtask

    // Waits until every sample is taken and every report checked, then lets the pipeline settle.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (items_accepted != items_queued || sweeps_checked != sweeps_issued);
        repeat (IdleSettle) @(negedge clk);
    endtask

    // Sample driver: predicts each accepted item, then offers the next one or idles.
    always @(posedge clk)
    begin : drive_samples
        sensor_item_t       nxt;
        bit                 next_valid;
        logic [SampleW-1:0] next_sample;
        bit                 made_report;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample   <= '0;
            gap_left = 0;
        end
        else
        begin
            made_report = 1'b0;
            next_valid  = in_valid;
            next_sample = sample;
            if (in_valid && !in_stall)
            begin
                advance_sensor_model(sample, made_report);
                items_accepted <= items_accepted + 1;
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (send_idling && $urandom_range(0, 11) == 0)
                    gap_left = $urandom_range(1, 17) - 1;
                else if (sample_queue.size() > 0 &&
                         !(sample_queue[0].wait_drain &&
                           sweeps_issued + int'(made_report) != sweeps_checked))
                begin
                    nxt         = sample_queue.pop_front();
                    next_valid  = 1'b1;
                    next_sample = nxt.value;
                end
            end
            if (made_report)
                sweeps_issued <= sweeps_issued + 1;
            in_valid <= next_valid;
            sample   <= next_sample;
        end
    end

    // Report checker and receiver stall generator.
    always @(posedge clk)
    begin : check_reports
        line_report_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    report_mismatch("report with nothing expected, position", position, -1);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (position !== want.position)
                        report_mismatch("position", position, want.position);
                    if (prev_position !== want.prev_position)
                        report_mismatch("prev_position", prev_position, want.prev_position);
                    if (intersection !== want.intersection)
                        report_mismatch("intersection", intersection, want.intersection);
                    if (hit_count !== want.hit_count)
                        report_mismatch("hit_count", hit_count, want.hit_count);
                    if (hit_pattern !== want.hit_pattern)
                        report_mismatch("hit_pattern", hit_pattern, want.hit_pattern);
                    sweeps_checked <= sweeps_checked + 1;
                end
            end
            // A requested long hold fills the block while the sender keeps offering.
            if (hold_left > 0)
                hold_left--;
            else if (holds_served != hold_requests)
            begin
                hold_left = LongHold;
                holds_served++;
            end
            if (stall_left > 0)
                stall_left--;
            else if (recv_idling && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 17);
            out_stall <= (hold_left > 0) || (stall_left > 0);
        end
    end

    // Test sequence: directed sweeps first, then random phases under several threshold sets.
    initial
    begin : run_phases
        for (int ch = 0; ch < NumCh; ch++)
            thr_model[ch] = thr_reset(ChW'(ch));
        chan_model    = '0;
        pattern_model = '0;
        count_model   = '0;
        pos_model     = CodeInit;
        last_model    = CodeInit;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Unlisted pattern before any match keeps the initial code, then the all-clear code.
        queue_extreme_sweep(8'hA5);
        queue_extreme_sweep(8'h00);
        wait_idle();

        // Top thresholds can never be hit; writes to unused indexes must be ignored.
        program_thresholds(THR_ALL_MAX);
        for (int idx = ThrIndexLast + 1; idx < 2**CfgIndexW; idx++)
            write_threshold(CfgIndexW'(idx), ThrW'($urandom));
        @(negedge clk);
        queue_extreme_sweep(8'hFF);
        wait_idle();

        // Zero thresholds: any nonzero sample hits.
        program_thresholds(THR_ALL_ZERO);
        send_idling = 1'b1;
        recv_idling = 1'b1;
        queue_random_sweeps(8, 0);
        wait_idle();

        // Receiver holds off long while the sender streams without gaps.
        program_thresholds(THR_MIXED);
        send_idling = 1'b0;
        hold_requests++;
        queue_random_sweeps(8, 0);
        wait_idle();

        // Sender pauses for a full drain before some sweeps.
        program_thresholds(THR_MIXED);
        send_idling = 1'b1;
        queue_random_sweeps(10, 3);
        wait_idle();

        for (int p = 0; p < 4; p++)
        begin
            program_thresholds(THR_MIXED);
            queue_random_sweeps(11, 0);
            wait_idle();
        end

        // Last stretch runs at full rate on both sides; pending stalls run out during setup.
        send_idling = 1'b0;
        recv_idling = 1'b0;
        program_thresholds(THR_MIXED);
        queue_random_sweeps(10, 0);
        wait_idle();
        repeat (10) @(negedge clk);

        if (expected_reports.size() != 0)
            report_mismatch("reports never received", 0, expected_reports.size());
        if (error_count == 0)
            $display("[line_sensor_position_encoder] OK");
        else
            $display("[line_sensor_position_encoder] ERROR");
        $finish;
    end

    // Hard limit on the run time.
    initial
    begin
        #5000000;
        $display("[line_sensor_position_encoder] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/lspe_pkg.sv
rtl/core/line_sensor_position_encoder.sv
sim/line_sensor_position_encoder_tb.sv
